// ===== rtl/core/vlcbp_pkg.sv =====
// shared constants and control types for the variable length code bit packer
`timescale 1ns / 1ps

package vlcbp_pkg;

    // default and widest code length the packer handles
    localparam int MAX_CODE_BITS_DEF = 64;

    // fixed field widths on the ports
    localparam int CODE_VALUE_W = 64;
    localparam int CODE_LEN_W   = 7;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 3;
    localparam int S_TDATA_W    = 72;
    localparam int M_TDATA_W    = 8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture a new code from the input transfer
        logic push_data;   // emit a completed data byte
        logic merge;       // fold the leftover code bits into the partial byte
        logic push_count;  // emit the valid bit count byte
        logic push_tail;   // emit the left aligned partial byte
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic full;        // partial bits plus remaining code bits reach a byte
        logic cnt_zero;    // no bits held in the partial byte
        logic last;        // current code closes the stream
        logic can_push;    // output register free this cycle
    } dp_stat_t;

endpackage

// ===== rtl/core/variable_length_code_bit_packer.sv =====
// top level of the variable length code bit packer
`timescale 1ns / 1ps

// Packs variable length codes into a byte stream, most significant bit first.
// Input channel (s_): one transfer per code with its value, its length (0 to
// 64, longer lengths saturate to MAX_CODE_BITS) and s_tlast on the final code.
// Output channel (m_): one byte per transfer; m_tlast marks the final byte
// of a stream. After the final code the block sends a count byte with the
// valid bits of the trailing partial byte, then that byte left aligned when
// the count is nonzero.
// Throughput: a code is loaded, then each completed byte is emitted, then the
// leftover bits are folded into the partial byte; the final code then adds
// the count byte and, if the count is nonzero, the tail byte. The pace is set
// by the single byte wide extraction step over the code shift register, one
// byte per cycle while the receiver takes each byte.
// The first byte of a code is registered from the PACK state after the load.
// Reset (aresetn low, synchronous) empties the partial byte and output
// register and opens a fresh stream. When the receiver stalls, the current
// byte holds in the output register and packing waits; new codes are taken
// only after the previous one is fully packed.
module variable_length_code_bit_packer #(
    parameter int MAX_CODE_BITS = vlcbp_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // code_value [63:0], code_length [70:64], zero fill [71]
    input  logic [vlcbp_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // out_byte [7:0]
    output logic [vlcbp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready
);

    vlcbp_pkg::dp_cmd_t  cmd;
    vlcbp_pkg::dp_stat_t stat;

    // sequencing
    vlcbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bit packing and output register
    vlcbp_dpath #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .code_value  (s_tdata[vlcbp_pkg::CODE_VALUE_W-1:0]),
        .code_length (s_tdata[vlcbp_pkg::CODE_VALUE_W +: vlcbp_pkg::CODE_LEN_W]),
        .last_code   (s_tlast),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_byte    (m_tdata),
        .last_byte   (m_tlast)
    );

endmodule

// ===== rtl/core/vlcbp_ctrl.sv =====
// controller state machine sequencing load, byte emission and end of stream flush
`timescale 1ns / 1ps

module vlcbp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  vlcbp_pkg::dp_stat_t stat,
    output vlcbp_pkg::dp_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PACK,
        ST_COUNT,
        ST_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    // ready only between codes
    assign s_tready = (state_reg == ST_IDLE);

    // next state and command decode
    always_comb begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.push_data  = 1'b0;
        cmd.merge      = 1'b0;
        cmd.push_count = 1'b0;
        cmd.push_tail  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_PACK;
                end
            end
            ST_PACK: begin
                if (stat.full) begin
                    cmd.push_data = stat.can_push;
                end else begin
                    cmd.merge  = 1'b1;
                    state_next = stat.last ? ST_COUNT : ST_IDLE;
                end
            end
            ST_COUNT: begin
                if (stat.can_push) begin
                    cmd.push_count = 1'b1;
                    state_next     = stat.cnt_zero ? ST_IDLE : ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (stat.can_push) begin
                    cmd.push_tail = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/vlcbp_dpath.sv =====
// datapath: code shift register, partial byte, bit counters and output register
`timescale 1ns / 1ps

module vlcbp_dpath #(
    parameter int MAX_CODE_BITS = vlcbp_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [vlcbp_pkg::CODE_VALUE_W-1:0]  code_value,
    input  logic [vlcbp_pkg::CODE_LEN_W-1:0]    code_length,
    input  logic                                last_code,
    input  vlcbp_pkg::dp_cmd_t                  cmd,
    output vlcbp_pkg::dp_stat_t                 stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [vlcbp_pkg::BYTE_W-1:0]        out_byte,
    output logic                                last_byte
);

    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int BW = vlcbp_pkg::BYTE_W;
    localparam int CW = vlcbp_pkg::CNT_W;

    logic [MAX_CODE_BITS-1:0] code_reg;
    logic [MAX_CODE_BITS-1:0] code_next;
    logic [LW-1:0]            rem_reg;
    logic [LW-1:0]            rem_next;
    logic [BW-1:0]            pend_reg;
    logic [BW-1:0]            pend_next;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            cnt_next;
    logic                     last_reg;
    logic                     last_next;
    logic                     ovalid_reg;
    logic                     ovalid_next;
    logic [BW-1:0]            obyte_reg;
    logic [BW-1:0]            obyte_next;
    logic                     olast_reg;
    logic                     olast_next;

    logic [LW-1:0]            len_sat;
    logic [CW:0]              need;
    logic [BW-1:0]            cand;
    logic [LW:0]              total;
    logic                     push;

    // saturate the length to the code register size
    always_comb begin
        if (code_length > vlcbp_pkg::CODE_LEN_W'(MAX_CODE_BITS)) begin
            len_sat = LW'(MAX_CODE_BITS);
        end else begin
            len_sat = code_length[LW-1:0];
        end
    end

    // candidate byte: partial bits followed by the leading code bits
    assign need  = (CW + 1)'(BW) - {1'b0, cnt_reg};
    assign cand  = pend_reg | (code_reg[MAX_CODE_BITS-1 -: BW] >> cnt_reg);
    assign total = {1'b0, rem_reg} + (LW + 1)'(cnt_reg);

    assign stat.full     = (total >= (LW + 1)'(BW));
    assign stat.cnt_zero = (cnt_reg == '0);
    assign stat.last     = last_reg;
    assign stat.can_push = !ovalid_reg || m_tready;

    assign push = cmd.push_data || cmd.push_count || cmd.push_tail;

    // packing state update
    always_comb begin
        code_next = code_reg;
        rem_next  = rem_reg;
        pend_next = pend_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (cmd.load) begin
            // left align the used code bits, upper bits fall off
            code_next = code_value[MAX_CODE_BITS-1:0] << (LW'(MAX_CODE_BITS) - len_sat);
            rem_next  = len_sat;
            last_next = last_code;
        end else if (cmd.push_data) begin
            code_next = code_reg << need;
            rem_next  = rem_reg - LW'(need);
            pend_next = '0;
            cnt_next  = '0;
        end else if (cmd.merge) begin
            pend_next = cand;
            cnt_next  = cnt_reg + rem_reg[CW-1:0];
            rem_next  = '0;
        end else if (cmd.push_count && stat.cnt_zero) begin
            last_next = 1'b0;
        end else if (cmd.push_tail) begin
            pend_next = '0;
            cnt_next  = '0;
            last_next = 1'b0;
        end
    end

    // output register update
    always_comb begin
        ovalid_next = ovalid_reg && !m_tready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (push) begin
            ovalid_next = 1'b1;
            if (cmd.push_data) begin
                obyte_next = cand;
                olast_next = 1'b0;
            end else if (cmd.push_count) begin
                obyte_next = BW'(cnt_reg);
                olast_next = stat.cnt_zero;
            end else begin
                obyte_next = pend_reg;
                olast_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= '0;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            last_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
            last_reg   <= last_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        code_reg  <= code_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid  = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign last_byte = olast_reg;

endmodule
